// File: design/iou_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IoU package
// Shared defaults and the control bundle that travels with each transaction.
// ----------------------------------------------------------------------------
package iou_pkg;

  localparam int unsigned COORD_BITS_DEF      = 16;
  localparam int unsigned RATIO_FRAC_BITS_DEF = 16;

  typedef struct packed {
    logic valid;
    logic bad;
  } ctl_t;

endpackage

// File: design/iou_area_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IoU area front end
// Three registered steps: edge differences and overlap, the three area
// products, and the union with the invalid-box check.
// ----------------------------------------------------------------------------
module iou_area_stage #(
  parameter int unsigned COORD_BITS = iou_pkg::COORD_BITS_DEF,
  localparam int unsigned AREA_W    = 2 * COORD_BITS,
  localparam int unsigned UNION_W   = AREA_W + 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [COORD_BITS-1:0] a_left_i,
  input  logic [COORD_BITS-1:0] a_top_i,
  input  logic [COORD_BITS-1:0] a_right_i,
  input  logic [COORD_BITS-1:0] a_bottom_i,
  input  logic [COORD_BITS-1:0] b_left_i,
  input  logic [COORD_BITS-1:0] b_top_i,
  input  logic [COORD_BITS-1:0] b_right_i,
  input  logic [COORD_BITS-1:0] b_bottom_i,
  output iou_pkg::ctl_t         ctl_o,
  output logic [AREA_W-1:0]     inter_o,
  output logic [UNION_W-1:0]    union_o
);

  logic [COORD_BITS-1:0] wa_d, ha_d, wb_d, hb_d, iw_d, ih_d;
  logic [COORD_BITS-1:0] wa_q, ha_q, wb_q, hb_q, iw_q, ih_q;
  logic [COORD_BITS-1:0] ix1, iy1, ix2, iy2;
  iou_pkg::ctl_t         s1_d, s1_q, s2_q, s3_d, s3_q;
  logic [AREA_W-1:0]     area_a_q, area_b_q, inter_q, inter3_q;
  logic [UNION_W-1:0]    union_d, union_q;

  always_comb begin
    ix1  = (a_left_i > b_left_i) ? a_left_i : b_left_i;
    iy1  = (a_top_i > b_top_i) ? a_top_i : b_top_i;
    ix2  = (a_right_i < b_right_i) ? a_right_i : b_right_i;
    iy2  = (a_bottom_i < b_bottom_i) ? a_bottom_i : b_bottom_i;
    iw_d = (ix2 > ix1) ? ix2 - ix1 : '0;
    ih_d = (iy2 > iy1) ? iy2 - iy1 : '0;
    wa_d = a_right_i - a_left_i;
    ha_d = a_bottom_i - a_top_i;
    wb_d = b_right_i - b_left_i;
    hb_d = b_bottom_i - b_top_i;
    s1_d.valid = valid_i;
    s1_d.bad   = (a_right_i < a_left_i) || (a_bottom_i < a_top_i) ||
                 (b_right_i < b_left_i) || (b_bottom_i < b_top_i);
    union_d    = {1'b0, area_a_q} + {1'b0, area_b_q} - {1'b0, inter_q};
    s3_d.valid = s2_q.valid;
    s3_d.bad   = s2_q.bad || (union_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
      s3_q <= '0;
    end else if (en_i) begin
      s1_q <= s1_d;
      s2_q <= s1_q;
      s3_q <= s3_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      wa_q     <= wa_d;
      ha_q     <= ha_d;
      wb_q     <= wb_d;
      hb_q     <= hb_d;
      iw_q     <= iw_d;
      ih_q     <= ih_d;
      area_a_q <= wa_q * ha_q;
      area_b_q <= wb_q * hb_q;
      inter_q  <= iw_q * ih_q;
      inter3_q <= inter_q;
      union_q  <= union_d;
    end
  end

  assign ctl_o   = s3_q;
  assign inter_o = inter3_q;
  assign union_o = union_q;

endmodule

// File: design/iou_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IoU divider cell
// One restoring-division step: resolves one quotient bit and hands the
// shifted remainder, divisor and partial quotient to the next cell.
// ----------------------------------------------------------------------------
module iou_div_cell #(
  parameter int unsigned UNION_W = 33,
  parameter int unsigned Q_W     = 17,
  localparam int unsigned REM_W  = UNION_W + 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  iou_pkg::ctl_t      ctl_i,
  input  logic [REM_W-1:0]   rem_i,
  input  logic [UNION_W-1:0] den_i,
  input  logic [Q_W-1:0]     quo_i,
  output iou_pkg::ctl_t      ctl_o,
  output logic [REM_W-1:0]   rem_o,
  output logic [UNION_W-1:0] den_o,
  output logic [Q_W-1:0]     quo_o
);

  logic               fits;
  logic [REM_W-1:0]   rem_sub;
  iou_pkg::ctl_t      ctl_q;
  logic [REM_W-1:0]   rem_q;
  logic [UNION_W-1:0] den_q;
  logic [Q_W-1:0]     quo_q;

  always_comb begin
    fits    = rem_i >= {1'b0, den_i};
    rem_sub = fits ? rem_i - {1'b0, den_i} : rem_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= {rem_sub[REM_W-2:0], 1'b0};
      den_q <= den_i;
      quo_q <= {quo_i[Q_W-2:0], fits};
    end
  end

  assign ctl_o = ctl_q;
  assign rem_o = rem_q;
  assign den_o = den_q;
  assign quo_o = quo_q;

endmodule

// File: design/box_intersection_over_union.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounding-box intersection over union
// Scores the overlap of two axis-aligned boxes as a fixed-point fraction.
// ----------------------------------------------------------------------------
// The slave stream carries one box pair per transaction in tdata, eight
// coordinates of COORD_BITS each, box A first. The master stream returns one
// transaction per pair: tdata holds the ratio with RATIO_FRAC_BITS fraction
// bits, where 2^RATIO_FRAC_BITS means 1.0, and tuser flags an inverted box or
// an empty union, in which case the ratio is zero.
// A pair is scored by three area steps followed by a row of divider cells,
// one quotient bit per cell. The whole row advances together, and while the
// output is not stalled one pair enters and one result leaves every cycle.
// When the receiver stalls, the row holds its contents; a one-entry skid
// register at the input takes the transaction that arrives in that cycle, and
// tready drops while it is full. Reset empties the row and the skid register.
// ----------------------------------------------------------------------------
module box_intersection_over_union #(
  parameter int unsigned COORD_BITS      = iou_pkg::COORD_BITS_DEF,
  parameter int unsigned RATIO_FRAC_BITS = iou_pkg::RATIO_FRAC_BITS_DEF,
  localparam int unsigned IN_FIELDS_W    = 8 * COORD_BITS,
  localparam int unsigned IN_DATA_W      = ((IN_FIELDS_W + 7) / 8) * 8,
  localparam int unsigned RATIO_W        = RATIO_FRAC_BITS + 1,
  localparam int unsigned OUT_DATA_W     = ((RATIO_W + 7) / 8) * 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // a_left, a_top, a_right, a_bottom, b_left, b_top, b_right, b_bottom
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // overlap_ratio
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // bad_boxes
  output logic                  m_axis_tuser
);

  localparam int unsigned AREA_W  = 2 * COORD_BITS;
  localparam int unsigned UNION_W = AREA_W + 1;
  localparam int unsigned REM_W   = UNION_W + 1;
  localparam int unsigned NCELL   = RATIO_W;

  logic                   en;
  logic                   skid_valid_d, skid_valid_q;
  logic [IN_FIELDS_W-1:0] skid_data_q;
  logic [IN_FIELDS_W-1:0] src_data;
  logic                   src_valid;
  logic                   in_fire;
  logic [RATIO_W-1:0]     ratio;

  iou_pkg::ctl_t          ctl [0:NCELL];
  logic [REM_W-1:0]       rem [0:NCELL];
  logic [UNION_W-1:0]     den [0:NCELL];
  logic [RATIO_W-1:0]     quo [0:NCELL];
  logic [AREA_W-1:0]      inter;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !skid_valid_q;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign src_valid     = skid_valid_q || in_fire;
  assign src_data      = skid_valid_q ? skid_data_q : s_axis_tdata[IN_FIELDS_W-1:0];

  always_comb begin
    skid_valid_d = skid_valid_q;
    if (en) begin
      skid_valid_d = 1'b0;
    end else if (in_fire) begin
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_valid_q <= 1'b0;
    end else begin
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && !en) begin
      skid_data_q <= s_axis_tdata[IN_FIELDS_W-1:0];
    end
  end

  iou_area_stage #(
    .COORD_BITS(COORD_BITS)
  ) u_area (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (src_valid),
    .a_left_i   (src_data[0*COORD_BITS +: COORD_BITS]),
    .a_top_i    (src_data[1*COORD_BITS +: COORD_BITS]),
    .a_right_i  (src_data[2*COORD_BITS +: COORD_BITS]),
    .a_bottom_i (src_data[3*COORD_BITS +: COORD_BITS]),
    .b_left_i   (src_data[4*COORD_BITS +: COORD_BITS]),
    .b_top_i    (src_data[5*COORD_BITS +: COORD_BITS]),
    .b_right_i  (src_data[6*COORD_BITS +: COORD_BITS]),
    .b_bottom_i (src_data[7*COORD_BITS +: COORD_BITS]),
    .ctl_o      (ctl[0]),
    .inter_o    (inter),
    .union_o    (den[0])
  );

  assign rem[0] = {2'b00, inter};
  assign quo[0] = '0;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    iou_div_cell #(
      .UNION_W (UNION_W),
      .Q_W     (RATIO_W)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctl_i  (ctl[i]),
      .rem_i  (rem[i]),
      .den_i  (den[i]),
      .quo_i  (quo[i]),
      .ctl_o  (ctl[i+1]),
      .rem_o  (rem[i+1]),
      .den_o  (den[i+1]),
      .quo_o  (quo[i+1])
    );
  end

  assign ratio         = ctl[NCELL].bad ? '0 : quo[NCELL];
  assign m_axis_tvalid = ctl[NCELL].valid;
  assign m_axis_tuser  = ctl[NCELL].bad;
  assign m_axis_tdata  = {{(OUT_DATA_W - RATIO_W){1'b0}}, ratio};

  a_bad_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> ratio == '0)
    else $error("flagged result carries a nonzero ratio");

  a_ratio_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |->
      quo[NCELL] <= {1'b1, {RATIO_FRAC_BITS{1'b0}}})
    else $error("ratio above one");

  a_skid_catch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !en |=> skid_valid_q)
    else $error("transaction taken during a stall was not held");

  a_skid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q && !en |=> skid_valid_q && $stable(skid_data_q))
    else $error("skid register lost its transaction");

  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q && en |=> !skid_valid_q)
    else $error("skid register did not drain");

endmodule
